// ----- sv/mmpu_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpu_pkg
// Shared types, constants and helpers for the modular multiply / power unit.
// ----------------------------------------------------------------------------
package mmpu_pkg;

    localparam int DATA_W    = 64;
    localparam int MOD_W     = 63;
    localparam int WIDTH     = 64;
    localparam int DIV_STEPS = DATA_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 1;
    localparam int STATUS_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_USE_MODULUS = 1'b0,
        CFG_MODULUS     = 1'b1
    } t_cfg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NEG_EXP   = 2'd1,
        ST_ZERO_ZERO = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_DIV_A,
        DP_DIV_STEP,
        DP_BASE_DIV_B,
        DP_MUL_AB,
        DP_PLAIN_MUL,
        DP_POW_INIT,
        DP_MUL_ACC,
        DP_MUL_SQR,
        DP_MUL_STEP,
        DP_STORE_ACC,
        DP_STORE_BASE,
        DP_OUT_LOAD
    } t_dp_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RED_A,
        S_RED_A_END,
        S_RED_B,
        S_RED_B_END,
        S_MUL_PROD,
        S_POW_TEST,
        S_MUL_ACC,
        S_MUL_SQR,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic op;
        logic modular;
        logic err;
        logic div_last;
        logic mul_done;
        logic exp_zero;
        logic exp_lsb;
    } t_dp_status;

    // Sign-extend from bit WIDTH-1 to the full data word.
    function automatic logic [DATA_W-1:0] wrap_width(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = (i < WIDTH) ? v[i] : v[WIDTH-1];
        end
        return r;
    endfunction

endpackage

// ----- sv/mmpu_dp.sv -----
// ----------------------------------------------------------------------------
// mmpu_dp
// Datapath: configuration registers, bit-serial signed reduction, shared
// shift-and-add multiplier, power registers and the result register.
// ----------------------------------------------------------------------------
module mmpu_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmpu_pkg::t_dp_cmd                   i_cmd,
    output mmpu_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_we,
    input  logic [mmpu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mmpu_pkg::MOD_W-1:0]          i_cfg_data,
    input  logic                                i_op,
    input  logic [mmpu_pkg::DATA_W-1:0]         i_a,
    input  logic [mmpu_pkg::DATA_W-1:0]         i_b,
    output logic [mmpu_pkg::DATA_W-1:0]         o_value,
    output logic [mmpu_pkg::STATUS_W-1:0]       o_status_code
);
    import mmpu_pkg::*;

    logic                r_use_mod;
    logic [MOD_W-1:0]    r_mod;
    logic                r_op;
    logic                r_modular;
    t_status             r_err;
    logic [DATA_W-1:0]   r_a;
    logic [DATA_W-1:0]   r_b;
    logic [DATA_W-1:0]   r_dvd;
    logic [DATA_W-1:0]   r_rem;
    logic                r_neg;
    logic [CNT_W-1:0]    r_cnt;
    logic [DATA_W-1:0]   r_mx;
    logic [DATA_W-1:0]   r_my;
    logic [DATA_W-1:0]   r_mr;
    logic [DATA_W-1:0]   r_base;
    logic [DATA_W-1:0]   r_acc;
    logic [DATA_W-1:0]   r_exp;
    logic [DATA_W-1:0]   r_value;
    t_status             r_status_code;

    logic [DATA_W-1:0]   m_ext;
    logic [DATA_W-1:0]   fix_val;
    logic [DATA_W-1:0]   t_shift;
    logic [DATA_W-1:0]   n_rem;
    logic [DATA_W-1:0]   sum;
    logic [DATA_W-1:0]   dbl;
    logic [DATA_W-1:0]   n_mr;
    logic [DATA_W-1:0]   n_mx;
    logic [DATA_W-1:0]   res;
    t_status             n_err;

    assign m_ext   = {1'b0, r_mod};
    assign fix_val = (r_neg && (r_rem != '0)) ? (m_ext - r_rem) : r_rem;
    assign t_shift = {r_rem[DATA_W-2:0], r_dvd[DATA_W-1]};
    assign n_rem   = (t_shift >= m_ext) ? (t_shift - m_ext) : t_shift;
    assign sum     = r_mr + r_mx;
    assign dbl     = {r_mx[DATA_W-2:0], 1'b0};
    assign n_mr    = (r_modular && (sum >= m_ext)) ? (sum - m_ext) : sum;
    assign n_mx    = (r_modular && (dbl >= m_ext)) ? (dbl - m_ext) : dbl;
    assign res     = r_op ? r_acc : r_mr;

    always_comb begin
        n_err = ST_OK;
        if (i_op) begin
            if (i_b[DATA_W-1]) begin
                n_err = ST_NEG_EXP;
            end else if ((i_a == '0) && (i_b == '0)) begin
                n_err = ST_ZERO_ZERO;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_mod <= 1'b0;
            r_mod     <= MOD_W'(1);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_USE_MODULUS: r_use_mod <= i_cfg_data[0];
                CFG_MODULUS:     r_mod     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LOAD: begin
                r_op      <= i_op;
                r_a       <= i_a;
                r_b       <= i_b;
                r_err     <= n_err;
                r_modular <= r_use_mod && (r_mod != '0);
            end
            DP_DIV_A: begin
                r_dvd <= r_a[DATA_W-1] ? (~r_a + DATA_W'(1)) : r_a;
                r_neg <= r_a[DATA_W-1];
                r_rem <= '0;
                r_cnt <= '0;
            end
            DP_DIV_STEP: begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            DP_BASE_DIV_B: begin
                r_base <= fix_val;
                r_dvd  <= r_b[DATA_W-1] ? (~r_b + DATA_W'(1)) : r_b;
                r_neg  <= r_b[DATA_W-1];
                r_rem  <= '0;
                r_cnt  <= '0;
            end
            DP_MUL_AB: begin
                r_mx <= r_base;
                r_my <= fix_val;
                r_mr <= '0;
            end
            DP_PLAIN_MUL: begin
                r_mx <= r_a;
                r_my <= r_b;
                r_mr <= '0;
            end
            DP_POW_INIT: begin
                r_base <= r_modular ? fix_val : r_a;
                r_acc  <= (r_modular && (r_mod == MOD_W'(1))) ? '0 : DATA_W'(1);
                r_exp  <= r_b;
            end
            DP_MUL_ACC: begin
                r_mx <= r_acc;
                r_my <= r_base;
                r_mr <= '0;
            end
            DP_MUL_SQR: begin
                r_mx <= r_base;
                r_my <= r_base;
                r_mr <= '0;
            end
            DP_MUL_STEP: begin
                if (r_my[0]) begin
                    r_mr <= n_mr;
                end
                r_mx <= n_mx;
                r_my <= {1'b0, r_my[DATA_W-1:1]};
            end
            DP_STORE_ACC: begin
                r_acc    <= r_mr;
                r_exp[0] <= 1'b0;
            end
            DP_STORE_BASE: begin
                r_base <= r_mr;
                r_exp  <= {1'b0, r_exp[DATA_W-1:1]};
            end
            DP_OUT_LOAD: begin
                r_status_code <= r_err;
                if (r_err != ST_OK) begin
                    r_value <= '0;
                end else begin
                    r_value <= r_modular ? res : wrap_width(res);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status.op       = r_op;
    assign o_status.modular  = r_modular;
    assign o_status.err      = (r_err != ST_OK);
    assign o_status.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_status.mul_done = (r_my == '0);
    assign o_status.exp_zero = (r_exp == '0);
    assign o_status.exp_lsb  = r_exp[0];

    assign o_value       = r_value;
    assign o_status_code = r_status_code;

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_DIV_STEP) |-> (r_rem < m_ext))
        else $error("reduction remainder reached the modulus");

    a_mul_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_MUL_STEP) && r_modular |-> (r_mx < m_ext) && (r_mr < m_ext))
        else $error("modular product operand out of range");

endmodule

// ----- sv/mmpu_ctrl.sv -----
// ----------------------------------------------------------------------------
// mmpu_ctrl
// Controller: sequences reduction, products and exponent bits, and owns the
// stream handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module mmpu_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  mmpu_pkg::t_dp_status  i_status,
    output mmpu_pkg::t_dp_cmd     o_cmd
);
    import mmpu_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    t_dp_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        cmd        = DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd     = DP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.err) begin
                    n_state = S_EMIT;
                end else if (i_status.modular) begin
                    cmd     = DP_DIV_A;
                    n_state = S_RED_A;
                end else if (!i_status.op) begin
                    cmd     = DP_PLAIN_MUL;
                    n_state = S_MUL_PROD;
                end else begin
                    cmd     = DP_POW_INIT;
                    n_state = S_POW_TEST;
                end
            end
            S_RED_A: begin
                cmd = DP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_RED_A_END;
                end
            end
            S_RED_A_END: begin
                if (!i_status.op) begin
                    cmd     = DP_BASE_DIV_B;
                    n_state = S_RED_B;
                end else begin
                    cmd     = DP_POW_INIT;
                    n_state = S_POW_TEST;
                end
            end
            S_RED_B: begin
                cmd = DP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = S_RED_B_END;
                end
            end
            S_RED_B_END: begin
                cmd     = DP_MUL_AB;
                n_state = S_MUL_PROD;
            end
            S_MUL_PROD: begin
                if (i_status.mul_done) begin
                    n_state = S_EMIT;
                end else begin
                    cmd = DP_MUL_STEP;
                end
            end
            S_POW_TEST: begin
                if (i_status.exp_zero) begin
                    n_state = S_EMIT;
                end else if (i_status.exp_lsb) begin
                    cmd     = DP_MUL_ACC;
                    n_state = S_MUL_ACC;
                end else begin
                    cmd     = DP_MUL_SQR;
                    n_state = S_MUL_SQR;
                end
            end
            S_MUL_ACC: begin
                if (i_status.mul_done) begin
                    cmd     = DP_STORE_ACC;
                    n_state = S_POW_TEST;
                end else begin
                    cmd = DP_MUL_STEP;
                end
            end
            S_MUL_SQR: begin
                if (i_status.mul_done) begin
                    cmd     = DP_STORE_BASE;
                    n_state = S_POW_TEST;
                end else begin
                    cmd = DP_MUL_STEP;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd     = DP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd == DP_OUT_LOAD) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_cmd       = cmd;
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd == DP_OUT_LOAD) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");

endmodule

// ----- sv/modular_multiply_power_unit.sv -----
// ----------------------------------------------------------------------------
// modular_multiply_power_unit
// Multiply or power of two signed operands, plain (wrapping) or modular.
//
//   channel   dir  tdata                                  tuser
//   s_axis    in   [63:0] operand_a, [127:64] operand_b   [0] op
//   m_axis    out  [63:0] value                           [1:0] status
//   cfg       in   i_cfg_idx 0 use_modulus, 1 modulus; i_cfg_data [62:0]
//
// One item at a time. A product runs one shift-and-add step per multiplier
// bit (up to 64) in the shared unit; modular mode first reduces both multiply
// operands, or the power's base, in the bit-serial reduction. A power takes
// up to two products per exponent bit.
// Reset gives plain mode and modulus 1; no clearing pass.
// A held result stalls only the next emit; the next item is still taken.
// ----------------------------------------------------------------------------
module modular_multiply_power_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [127:0]                      s_axis_tdata,  // operand_a, operand_b
    input  logic [0:0]                        s_axis_tuser,  // op
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [63:0]                       m_axis_tdata,  // value
    output logic [1:0]                        m_axis_tuser,  // status
    input  logic                              i_cfg_we,
    input  logic [mmpu_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mmpu_pkg::MOD_W-1:0]        i_cfg_data
);
    import mmpu_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status dp_status;

    mmpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    mmpu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (dp_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_op          (s_axis_tuser[0]),
        .i_a           (s_axis_tdata[DATA_W-1:0]),
        .i_b           (s_axis_tdata[2*DATA_W-1:DATA_W]),
        .o_value       (m_axis_tdata),
        .o_status_code (m_axis_tuser)
    );

endmodule

// ----- test/tb_mmpu_ops_pkg.sv -----
// ----------------------------------------------------------------------------
// tb_mmpu_ops_pkg
// Operation codes of the multiply / power unit, shared by the stimulus and
// the result checker.
// ----------------------------------------------------------------------------
package tb_mmpu_ops_pkg;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_POW = 1'b1
    } t_op;

endpackage

// ----- test/mmpu_result_checker.sv -----
// ----------------------------------------------------------------------------
// mmpu_result_checker
// Watches the input, output and register ports of the multiply / power unit.
// Keeps its own copy of the mode and modulus, works out the value and status
// of every accepted item and compares each emitted item with the oldest one.
// ----------------------------------------------------------------------------
module mmpu_result_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [127:0]                   s_axis_tdata,  // operand_a, operand_b
    input  logic [0:0]                     s_axis_tuser,  // op
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [63:0]                    m_axis_tdata,  // value
    input  logic [1:0]                     m_axis_tuser,  // status
    input  logic                           i_cfg_we,
    input  logic [mmpu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mmpu_pkg::MOD_W-1:0]     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_awaiting
);
    import mmpu_pkg::*;
    import tb_mmpu_ops_pkg::*;

    typedef struct packed {
        logic [63:0] value;
        t_status     status;
    } t_mulpow;

    logic        mod_enable = 1'b0;
    logic [62:0] mod_value  = 63'd1;
    t_mulpow     expected_mulpow[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    // Non-negative remainder of a signed word.
    function automatic logic [63:0] residue(input logic [63:0] v);
        logic [63:0] m;
        logic [63:0] r;
        m = {1'b0, mod_value};
        if (v[63]) begin
            r = (~v + 64'd1) % m;
            return (r == 64'd0) ? 64'd0 : m - r;
        end
        return v % m;
    endfunction

    function automatic logic [63:0] mulmod(input logic [63:0] x, input logic [63:0] y);
        logic [127:0] p;
        p = ({64'd0, x} * {64'd0, y}) % {65'd0, mod_value};
        return p[63:0];
    endfunction

    function automatic logic [63:0] width_wrap(input logic [63:0] v);
        logic [63:0] r;
        r = v;
        for (int i = WIDTH; i < 64; i++) begin
            r[i] = v[WIDTH-1];
        end
        return r;
    endfunction

    function automatic t_mulpow compute_mulpow(input t_op op, input logic [63:0] a,
                                               input logic [63:0] b);
        t_mulpow     res;
        logic        modular;
        logic [63:0] base;
        logic [63:0] acc;
        logic [63:0] e;
        modular    = mod_enable && (mod_value != 63'd0);
        res.value  = 64'd0;
        res.status = ST_OK;
        if (op == OP_MUL) begin
            if (modular) begin
                res.value = mulmod(residue(a), residue(b));
            end else begin
                res.value = width_wrap(a * b);
            end
        end else if (b[63]) begin
            res.status = ST_NEG_EXP;
        end else if (a == 64'd0 && b == 64'd0) begin
            res.status = ST_ZERO_ZERO;
        end else begin
            e = b;
            if (modular) begin
                base = residue(a);
                acc  = (mod_value == 63'd1) ? 64'd0 : 64'd1;
            end else begin
                base = a;
                acc  = 64'd1;
            end
            while (e != 64'd0) begin
                if (e[0]) begin
                    acc = modular ? mulmod(acc, base) : acc * base;
                end
                base = modular ? mulmod(base, base) : base * base;
                e    = e >> 1;
            end
            res.value = modular ? acc : width_wrap(acc);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_mulpow want;
        if (!i_rst_n) begin
            mod_enable = 1'b0;
            mod_value  = 63'd1;
            expected_mulpow.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_USE_MODULUS: mod_enable = i_cfg_data[0];
                    CFG_MODULUS:     mod_value  = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_mulpow.push_back(compute_mulpow(t_op'(s_axis_tuser[0]),
                                                         s_axis_tdata[63:0],
                                                         s_axis_tdata[127:64]));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_mulpow.size() == 0) begin
                    $error("value: expected no item, got %h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_mulpow.pop_front();
                    if (m_axis_tdata !== want.value) begin
                        $error("value: expected %h, got %h", want.value, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
        end
        o_awaiting = expected_mulpow.size();
    end

endmodule

// ----- test/tb_modular_multiply_power_unit.sv -----
// ----------------------------------------------------------------------------
// tb_modular_multiply_power_unit
// Drives directed and random multiply / power items through the unit across
// plain and modular settings, with random idling on both streams and one
// long output stall; the result checker flags every mismatch.
// ----------------------------------------------------------------------------
module tb_modular_multiply_power_unit;
    import mmpu_pkg::*;
    import tb_mmpu_ops_pkg::*;

    localparam int          LIMIT_CYCLES = 5_000_000;
    localparam int          HOLD_CYCLES  = 2000;
    localparam int          SEGMENTS     = 10;
    localparam int          SEG_ITEMS    = 7;
    localparam logic [63:0] MAX_S        = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_S        = 64'h8000_0000_0000_0000;
    localparam logic [62:0] MOD_MAX      = '1;

    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 s_axis_tvalid  = 1'b0;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata   = '0;
    logic [0:0]           s_axis_tuser   = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready  = 1'b0;
    logic [63:0]          m_axis_tdata;
    logic [1:0]           m_axis_tuser;
    logic                 i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx      = CFG_USE_MODULUS;
    logic [MOD_W-1:0]     i_cfg_data     = '0;

    int          fail_count;
    int          awaiting;
    int          tx_idle_pct = 25;
    int          rx_idle_pct = 79;
    int          hold_req    = 0;
    longint      cycle_count = 0;

    modular_multiply_power_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    mmpu_result_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_awaiting    (awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[modular_multiply_power_unit] ERROR");
        $finish;
    end

    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_req = 0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Returns on a falling edge with valid still high; the caller drops it.
    task automatic offer_operands(input t_op op, input logic [63:0] a, input logic [63:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_mode(input logic use_mod, input logic [62:0] m);
        s_axis_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_USE_MODULUS;
        i_cfg_data <= {62'd0, use_mod};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_MODULUS;
        i_cfg_data <= m;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [63:0] random_operand();
        case ($urandom_range(5))
            0:       return 64'($signed($urandom_range(40)) - 20);
            1:       return MAX_S;
            2:       return MIN_S;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] random_exponent();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       r[63] = 1'b1;
            1:       r[63] = 1'b0;
            2:       r = 64'd0;
            default: r = 64'($urandom_range(1, 300));
        endcase
        return r;
    endfunction

    initial begin : stimulus
        t_op         op;
        logic [63:0] a;
        logic [63:0] r;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // plain mode straight out of reset
        offer_operands(OP_MUL, MAX_S, MAX_S);
        offer_operands(OP_MUL, MIN_S, -64'sd1);
        offer_operands(OP_MUL, MIN_S, MIN_S);
        offer_operands(OP_MUL, 64'd0, {$urandom, $urandom});
        offer_operands(OP_MUL, -64'sd3, 64'd5);
        offer_operands(OP_POW, 64'd3, -64'sd1);
        offer_operands(OP_POW, 64'd0, 64'd0);
        offer_operands(OP_POW, 64'd0, MIN_S);
        offer_operands(OP_POW, -64'sd5, 64'd0);
        offer_operands(OP_POW, 64'd2, 64'd63);
        offer_operands(OP_POW, -64'sd1, MAX_S);
        offer_operands(OP_POW, 64'd0, 64'd7);

        set_mode(1'b1, 63'd7);
        offer_operands(OP_MUL, -64'sd7, 64'd5);
        offer_operands(OP_MUL, -64'sd3, -64'sd5);
        offer_operands(OP_POW, -64'sd2, 64'd3);
        offer_operands(OP_POW, 64'd5, 64'd0);
        offer_operands(OP_POW, 64'd0, 64'd0);
        offer_operands(OP_POW, MIN_S, MAX_S);

        set_mode(1'b1, 63'd1);
        offer_operands(OP_POW, 64'd5, 64'd0);
        offer_operands(OP_MUL, MAX_S, MIN_S);

        set_mode(1'b1, MOD_MAX);
        offer_operands(OP_MUL, MIN_S, MAX_S);
        offer_operands(OP_POW, 64'd3, MAX_S);

        // modulus of zero falls back to plain wrapping
        set_mode(1'b1, 63'd0);
        offer_operands(OP_MUL, MAX_S, MAX_S);
        offer_operands(OP_POW, 64'd3, 64'd41);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == SEGMENTS / 3) begin
                tx_idle_pct = 79;
                rx_idle_pct = 25;
            end else if (seg == 2 * SEGMENTS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            r = {$urandom, $urandom};
            case ($urandom_range(5))
                0:       set_mode(1'b0, r[62:0]);
                1:       set_mode(1'b1, 63'($urandom_range(2, 1000)));
                2:       set_mode(1'b1, r[62:0]);
                3:       set_mode(1'b1, MOD_MAX);
                4:       set_mode(1'b1, 63'd1);
                default: set_mode(1'b1, 63'd0);
            endcase
            if (seg == SEGMENTS / 2) begin
                // stall the output long enough for the input to back up
                hold_req = 1;
                repeat (4) offer_operands(OP_MUL, random_operand(), random_operand());
            end
            repeat (SEG_ITEMS) begin
                op = ($urandom_range(1) == 1) ? OP_POW : OP_MUL;
                a  = random_operand();
                offer_operands(op, a, (op == OP_POW) ? random_exponent() : random_operand());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && awaiting == 0) begin
            $display("[modular_multiply_power_unit] OK");
        end else begin
            $display("[modular_multiply_power_unit] ERROR");
        end
        $finish;
    end

endmodule
